// ----- rtl/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on each rising edge while reset is released
`define BTLV_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// property checked on each rising edge, reset included
`define BTLV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BTLV_ASSERT(label, clk, rstn, prop, msg)
`define BTLV_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/btlv_pkg.sv -----
`timescale 1ns / 1ps

package btlv_pkg;

    localparam int BYTE_W   = 8;
    localparam int AVAIL_W  = 31;
    localparam int VALUE_W  = 33;
    localparam int STATUS_W = 3;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_WRONG_TAG  = 3'd1,
        ST_INDEF_LEN  = 3'd2,
        ST_LEN_FIELD  = 3'd3,
        ST_LEN_RANGE  = 3'd4,
        ST_MSG_OVFL   = 3'd5,
        ST_INT_LARGE  = 3'd6
    } status_t;

    // one input beat
    typedef struct packed {
        logic               command;
        logic               start_req;
        logic [BYTE_W-1:0]  data_byte;
        logic [AVAIL_W-1:0] available;
    } btlv_in_t;

    // one result beat
    typedef struct packed {
        status_t                    status;
        logic [BYTE_W-1:0]          tag;
        logic signed [VALUE_W-1:0]  value;
        logic [AVAIL_W-1:0]         remaining;
    } btlv_res_t;

endpackage

// ----- rtl/btlv_core.sv -----
`timescale 1ns / 1ps

module btlv_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  btlv_pkg::btlv_in_t  in_item,
    output logic                res_valid,
    output btlv_pkg::btlv_res_t res
);
    import btlv_pkg::*;

    localparam logic [7:0] TAG_INT     = 8'h02;
    localparam logic [7:0] TAG_COUNTER = 8'h41;
    localparam logic [7:0] TAG_GAUGE   = 8'h42;
    localparam logic [7:0] TAG_TICKS   = 8'h43;
    localparam logic [7:0] TAG_UINT64  = 8'h47;
    localparam logic [31:0] LEN_MAX    = 32'h8000_0000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN1,
        PH_LENX,
        PH_BODY
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               um_reg, um_next;
    logic [7:0]         tag_reg, tag_next;
    logic [2:0]         lbl_reg, lbl_next;
    logic [31:0]        lacc_reg, lacc_next;
    logic [2:0]         hc_reg, hc_next;
    logic [2:0]         cl_reg, cl_next;
    logic               fc_reg, fc_next;
    logic [31:0]        vacc_reg, vacc_next;
    logic [AVAIL_W-1:0] avail_reg, avail_next;

    logic [7:0]         b;
    logic               tag_good;
    logic [31:0]        lacc_shift;
    logic [31:0]        hd_len;
    logic [2:0]         hd_hc;
    logic [32:0]        hd_sum;
    logic               hd_ovfl;
    logic               hd_big;
    logic [AVAIL_W-1:0] hd_rem;
    logic [AVAIL_W-1:0] body_rem;
    logic               do_hd;
    logic               take;
    logic [31:0]        vacc_base;

    assign b = in_item.data_byte;

    // allowed tag set depends on signed or unsigned parsing
    assign tag_good = (b == TAG_INT) || (b == TAG_TICKS) || (b == TAG_COUNTER) ||
                      (in_item.command && ((b == TAG_GAUGE) || (b == TAG_UINT64)));

    // header check operands: short form in LEN1, last long-form byte in LENX
    assign lacc_shift = {lacc_reg[23:0], b};
    assign hd_len  = (phase_reg == PH_LEN1) ? {24'd0, b} : lacc_shift;
    assign hd_hc   = (phase_reg == PH_LEN1) ? 3'd2 : 3'(hc_reg + 3'd1);
    assign hd_sum  = {1'b0, hd_len} + {30'd0, hd_hc};
    assign hd_ovfl = hd_sum > {2'b00, avail_reg};
    assign hd_big  = hd_len > (um_reg ? 32'd5 : 32'd4);
    assign hd_rem  = avail_reg - {{(AVAIL_W-3){1'b0}}, hd_hc};
    // content length is at most 5 when the body ends
    assign body_rem = avail_reg - {{(AVAIL_W-3){1'b0}}, hc_reg}
                                - {{(AVAIL_W-3){1'b0}}, lacc_reg[2:0]};

    // next state and result for one byte
    always_comb begin
        phase_next = phase_reg;
        um_next    = um_reg;
        tag_next   = tag_reg;
        lbl_next   = lbl_reg;
        lacc_next  = lacc_reg;
        hc_next    = hc_reg;
        cl_next    = cl_reg;
        fc_next    = fc_reg;
        vacc_next  = vacc_reg;
        avail_next = avail_reg;
        res_valid  = 1'b0;
        res.status    = ST_OK;
        res.tag       = tag_reg;
        res.value     = '0;
        res.remaining = '0;
        do_hd      = 1'b0;
        take       = 1'b1;
        vacc_base  = vacc_reg;

        if (step_en) begin
            if (in_item.start_req) begin
                um_next    = in_item.command;
                tag_next   = b;
                avail_next = in_item.available;
                hc_next    = 3'd1;
                lacc_next  = '0;
                lbl_next   = '0;
                cl_next    = '0;
                fc_next    = 1'b0;
                vacc_next  = '0;
                res.tag    = b;
                if (!tag_good) begin
                    res_valid  = 1'b1;
                    res.status = ST_WRONG_TAG;
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_LEN1;
                end
            end else begin
                unique case (phase_reg)
                    PH_LEN1: begin
                        hc_next = 3'd2;
                        if (b[7]) begin
                            if (b[6:0] == 7'd0) begin
                                res_valid  = 1'b1;
                                res.status = ST_INDEF_LEN;
                                phase_next = PH_IDLE;
                            end else if (b[6:0] > 7'd4) begin
                                res_valid  = 1'b1;
                                res.status = ST_LEN_FIELD;
                                phase_next = PH_IDLE;
                            end else begin
                                lbl_next   = b[2:0];
                                lacc_next  = '0;
                                phase_next = PH_LENX;
                            end
                        end else begin
                            lacc_next = {24'd0, b};
                            do_hd     = 1'b1;
                        end
                    end
                    PH_LENX: begin
                        lacc_next = lacc_shift;
                        hc_next   = 3'(hc_reg + 3'd1);
                        lbl_next  = 3'(lbl_reg - 3'd1);
                        if (lbl_next == 3'd0) begin
                            if (lacc_shift > LEN_MAX) begin
                                res_valid  = 1'b1;
                                res.status = ST_LEN_RANGE;
                                phase_next = PH_IDLE;
                            end else begin
                                do_hd = 1'b1;
                            end
                        end
                    end
                    PH_BODY: begin
                        if (fc_reg) begin
                            fc_next = 1'b0;
                            if (um_reg) begin
                                if (b == 8'h00) begin
                                    take = 1'b0;
                                end else if (cl_reg == 3'd5) begin
                                    res_valid  = 1'b1;
                                    res.status = ST_INT_LARGE;
                                    phase_next = PH_IDLE;
                                end
                            end else if (b[7]) begin
                                vacc_base = 32'hFFFF_FFFF;
                            end
                        end
                        if (!res_valid) begin
                            vacc_next = take ? {vacc_base[23:0], b} : vacc_base;
                            cl_next   = 3'(cl_reg - 3'd1);
                            if (cl_next == 3'd0) begin
                                res_valid     = 1'b1;
                                res.status    = ST_OK;
                                res.value     = {(!um_reg && vacc_next[31]), vacc_next};
                                res.remaining = body_rem;
                                phase_next    = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase

                // header complete: check fit and size of the content
                if (do_hd) begin
                    if (hd_ovfl) begin
                        res_valid  = 1'b1;
                        res.status = ST_MSG_OVFL;
                        phase_next = PH_IDLE;
                    end else if (hd_big) begin
                        res_valid  = 1'b1;
                        res.status = ST_INT_LARGE;
                        phase_next = PH_IDLE;
                    end else if (hd_len == 32'd0) begin
                        res_valid     = 1'b1;
                        res.status    = ST_OK;
                        res.remaining = hd_rem;
                        phase_next    = PH_IDLE;
                    end else begin
                        cl_next    = hd_len[2:0];
                        fc_next    = 1'b1;
                        vacc_next  = '0;
                        phase_next = PH_BODY;
                    end
                end
            end
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            um_reg    <= 1'b0;
            tag_reg   <= '0;
            lbl_reg   <= '0;
            lacc_reg  <= '0;
            hc_reg    <= '0;
            cl_reg    <= '0;
            fc_reg    <= 1'b0;
            vacc_reg  <= '0;
            avail_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            um_reg    <= um_next;
            tag_reg   <= tag_next;
            lbl_reg   <= lbl_next;
            lacc_reg  <= lacc_next;
            hc_reg    <= hc_next;
            cl_reg    <= cl_next;
            fc_reg    <= fc_next;
            vacc_reg  <= vacc_next;
            avail_reg <= avail_next;
        end
    end

endmodule

// ----- rtl/ber_integer_tlv_stream_parser_unit.sv -----
`timescale 1ns / 1ps
// BER integer element parser, one encoded byte per input beat.
// Input channel s_axis: each beat carries one message byte plus the bytes still
// available; tuser bit 1 flags the tag byte of a new element and bit 0 picks
// unsigned (1) or signed (0) parsing, both sampled on that tag byte.
// Result channel m_axis: one beat per finished element with status in tuser,
// and tag, 33-bit value and remaining byte count in tdata. A failed check ends
// the element at once; later bytes are dropped until the next tag byte. A new
// tag byte in the middle of an element drops that element without a result.
// The byte that ends an element is first captured in the input register; the
// parser then updates from it and writes the result beat into the result
// register, from which it is presented on m_axis.
// One byte per cycle while the result channel is not stalled.
// When m_axis_tready is low the result register holds and s_axis_tready drops
// once the input register is full too, so no beat is lost.
// Reset (aresetn low, synchronous) empties both registers and sets the parser
// to wait for a tag byte.
`include "assert_macros.svh"

module ber_integer_tlv_stream_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte[7:0], available[38:8], zero[39]
    input  logic [1:0]  s_axis_tuser,   // command[0], start_req[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // tag[7:0], value[40:8], remaining[71:41]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);
    import btlv_pkg::*;

    logic      in_valid_reg;
    btlv_in_t  in_item_reg;
    logic      out_valid_reg;
    btlv_res_t out_res_reg;
    logic      advance;
    logic      s_fire;
    logic      core_res_valid;
    btlv_res_t core_res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.command   <= s_axis_tuser[0];
            in_item_reg.start_req <= s_axis_tuser[1];
            in_item_reg.data_byte <= s_axis_tdata[7:0];
            in_item_reg.available <= s_axis_tdata[38:8];
        end
    end

    btlv_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .in_item   (in_item_reg),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (core_res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_res_valid) begin
            out_res_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {out_res_reg.remaining, out_res_reg.value, out_res_reg.tag};

    // checks
    `BTLV_ASSERT(a_res_only_on_step, aclk, aresetn,
        !advance |-> !core_res_valid, "result without a byte step")
    `BTLV_ASSERT(a_res_slot_free, aclk, aresetn,
        core_res_valid |-> (!out_valid_reg || m_axis_tready), "result register overwritten")
    `BTLV_ASSERT(a_err_fields_zero, aclk, aresetn,
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata[71:8] == 64'd0),
        "error beat with nonzero value or remaining")
    `BTLV_ASSERT(a_out_from_core, aclk, aresetn,
        $rose(out_valid_reg) |-> $past(core_res_valid), "result beat not from parser")

endmodule

// ----- tb/sv/btlv_result_checker.sv -----
`timescale 1ns / 1ps

// tag codes and limits shared by the stimulus and the checker
package btlv_tb_pkg;

    localparam logic [7:0]  TAG_INTEGER   = 8'h02;
    localparam logic [7:0]  TAG_COUNTER   = 8'h41;
    localparam logic [7:0]  TAG_GAUGE     = 8'h42;
    localparam logic [7:0]  TAG_TIMETICKS = 8'h43;
    localparam logic [7:0]  TAG_UINTEGER  = 8'h47;
    localparam logic [7:0]  LEN_LONG_FORM = 8'h80;
    localparam logic [30:0] AVAIL_MAX     = 31'h7FFF_FFFF;
    localparam logic [31:0] LEN_CEILING   = 32'h8000_0000;

    // signed parsing takes three tags, unsigned parsing two more
    function automatic bit tag_allowed(logic [7:0] t, logic uns);
        return t == TAG_INTEGER || t == TAG_TIMETICKS || t == TAG_COUNTER
            || (uns && (t == TAG_GAUGE || t == TAG_UINTEGER));
    endfunction

endpackage

module btlv_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte[7:0], available[38:8], zero[39]
    input  logic [1:0]  s_axis_tuser,   // command[0], start_req[1]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,   // tag[7:0], value[40:8], remaining[71:41]
    input  logic [2:0]  m_axis_tuser,   // status[2:0]
    output int          n_fail,
    output int          n_pending
);

    import btlv_pkg::*;
    import btlv_tb_pkg::*;

    typedef enum logic [1:0] {
        WAIT_TAG,
        LEN_FIRST,
        LEN_MORE,
        CONTENT
    } parse_step_t;

    // decoder model state
    parse_step_t ph;
    logic        uns_mode;
    logic [7:0]  tag_q;
    logic [2:0]  len_left;
    logic [31:0] len_acc;
    logic [2:0]  hdr_cnt;
    logic [2:0]  body_left;
    logic        body_first;
    logic [31:0] val_acc;
    logic [30:0] avail_q;

    btlv_res_t decoded_elements[$];
    int        errs = 0;

    // queue one finished element and go back to waiting for a tag
    function automatic void finish_element(status_t st, logic signed [32:0] v,
                                           logic [30:0] rem);
        btlv_res_t r;
        r.status    = st;
        r.tag       = tag_q;
        r.value     = v;
        r.remaining = rem;
        decoded_elements.push_back(r);
        ph = WAIT_TAG;
    endfunction

    // length is known: check it against the message and the integer size
    function automatic void close_header();
        longint unsigned need;
        need = 64'(len_acc) + 64'(hdr_cnt);
        if (need > 64'(avail_q))
            finish_element(ST_MSG_OVFL, '0, '0);
        else if (len_acc > (uns_mode ? 32'd5 : 32'd4))
            finish_element(ST_INT_LARGE, '0, '0);
        else if (len_acc == 0)
            finish_element(ST_OK, '0, avail_q - 31'(hdr_cnt));
        else begin
            body_left  = len_acc[2:0];
            body_first = 1'b1;
            val_acc    = '0;
            ph         = CONTENT;
        end
    endfunction

    // advance the decoder by one accepted byte
    task automatic decode_ber_byte(input logic cmd, input logic start, input logic [7:0] b,
                                   input logic [30:0] avail);
        bit                 take;
        logic signed [32:0] v;
        take = 1'b1;
        if (start) begin
            uns_mode   = cmd;
            tag_q      = b;
            avail_q    = avail;
            hdr_cnt    = 3'd1;
            len_acc    = '0;
            len_left   = '0;
            body_left  = '0;
            body_first = 1'b0;
            val_acc    = '0;
            if (!tag_allowed(b, cmd))
                finish_element(ST_WRONG_TAG, '0, '0);
            else
                ph = LEN_FIRST;
            return;
        end
        case (ph)
            LEN_FIRST: begin
                hdr_cnt = 3'd2;
                if (b[7]) begin
                    if (b[6:0] == 0)
                        finish_element(ST_INDEF_LEN, '0, '0);
                    else if (b[6:0] > 7'd4)
                        finish_element(ST_LEN_FIELD, '0, '0);
                    else begin
                        len_left = b[2:0];
                        len_acc  = '0;
                        ph       = LEN_MORE;
                    end
                end else begin
                    len_acc = {24'd0, b};
                    close_header();
                end
            end
            LEN_MORE: begin
                len_acc  = {len_acc[23:0], b};
                hdr_cnt  = hdr_cnt + 3'd1;
                len_left = len_left - 3'd1;
                if (len_left == 0) begin
                    if (len_acc > LEN_CEILING)
                        finish_element(ST_LEN_RANGE, '0, '0);
                    else
                        close_header();
                end
            end
            CONTENT: begin
                // first content byte: leading zero skip or sign fill
                if (body_first) begin
                    body_first = 1'b0;
                    if (uns_mode) begin
                        if (b == 8'h00)
                            take = 1'b0;
                        else if (body_left == 3'd5) begin
                            finish_element(ST_INT_LARGE, '0, '0);
                            return;
                        end
                    end else if (b[7]) begin
                        val_acc = '1;
                    end
                end
                if (take)
                    val_acc = {val_acc[23:0], b};
                body_left = body_left - 3'd1;
                if (body_left == 0) begin
                    v = uns_mode ? {1'b0, val_acc} : {val_acc[31], val_acc};
                    finish_element(ST_OK, v, avail_q - 31'(hdr_cnt) - len_acc[30:0]);
                end
            end
            default: ;
        endcase
    endtask

    function automatic void compare_field(string fname, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            errs++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
        end
    endfunction

    // compare results first: a byte taken at this edge cannot have produced one yet
    always @(posedge aclk) begin
        btlv_res_t want;
        if (!aresetn) begin
            ph         = WAIT_TAG;
            uns_mode   = 1'b0;
            tag_q      = '0;
            len_left   = '0;
            len_acc    = '0;
            hdr_cnt    = '0;
            body_left  = '0;
            body_first = 1'b0;
            val_acc    = '0;
            avail_q    = '0;
            decoded_elements.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_elements.size() == 0) begin
                    errs++;
                    $display("%0t: result beat with none expected, expected nothing actual %0h_%0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = decoded_elements.pop_front();
                    compare_field("status", 64'(want.status), 64'(m_axis_tuser));
                    compare_field("tag", 64'(want.tag), 64'(m_axis_tdata[7:0]));
                    compare_field("value", 64'(want.value[32:0]), 64'(m_axis_tdata[40:8]));
                    compare_field("remaining", 64'(want.remaining), 64'(m_axis_tdata[71:41]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_ber_byte(s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata[7:0],
                                s_axis_tdata[38:8]);
        end
        n_fail    <= errs;
        n_pending <= decoded_elements.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import btlv_tb_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    int n_fail;
    int n_pending;
    int tx_idle_pct = 19;
    int rx_idle_pct = 56;
    int cycle_count = 0;
    int random_items = 0;

    // element under construction
    logic [7:0]  elem_q[$];
    logic        elem_cmd;
    logic [30:0] elem_avail;

    always #5 aclk = ~aclk;

    ber_integer_tlv_stream_parser_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    btlv_result_checker u_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .n_fail        (n_fail),
        .n_pending     (n_pending)
    );

    // receiver stalls at random
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one input beat, with random gaps before it
    task automatic send_beat(input logic cmd, input logic start, input logic [7:0] b,
                             input logic [30:0] avail);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, avail, b};
        s_axis_tuser  <= {start, cmd};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // fields sampled only on the tag byte get random values elsewhere
    task automatic send_element(input logic cmd, input logic [30:0] avail);
        int unsigned k;
        for (k = 0; k < elem_q.size(); k++)
            send_beat(k == 0 ? cmd : 1'($urandom_range(0, 1)), k == 0, elem_q[k],
                      k == 0 ? avail : 31'($urandom));
    endtask

    function automatic logic [7:0] pick_tag(logic uns);
        logic [7:0] tags [5] = '{TAG_INTEGER, TAG_TIMETICKS, TAG_COUNTER,
                                 TAG_GAUGE, TAG_UINTEGER};
        return tags[$urandom_range(0, uns ? 4 : 2)];
    endfunction

    // random element: mostly well formed, some cut short, the rest bad headers
    task automatic build_element();
        int unsigned mode, len, nlen, need, k;
        logic [7:0]  t;
        logic [31:0] big;
        elem_q.delete();
        elem_cmd   = 1'($urandom_range(0, 1));
        elem_avail = 31'($urandom);
        mode       = $urandom_range(0, 99);
        if (mode < 64) begin
            len = $urandom_range(0, elem_cmd ? 5 : 4);
            elem_q.push_back(pick_tag(elem_cmd));
            if ($urandom_range(0, 3) == 0) begin
                nlen = $urandom_range(1, 4);
                elem_q.push_back(LEN_LONG_FORM | 8'(nlen));
                for (k = nlen; k > 0; k--)
                    elem_q.push_back(8'(len >> (8 * (k - 1))));
            end else begin
                elem_q.push_back(8'(len));
            end
            for (k = 0; k < len; k++)
                elem_q.push_back(8'($urandom));
            // unsigned: five bytes need a leading zero, shorter ones may carry one
            if (elem_cmd && len == 5 && $urandom_range(0, 9) != 0)
                elem_q[elem_q.size() - 5] = 8'h00;
            else if (elem_cmd && len != 0 && $urandom_range(0, 3) == 0)
                elem_q[elem_q.size() - len] = 8'h00;
            need = elem_q.size();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: elem_avail = 31'(need + $urandom_range(0, 200));
                4, 5:       elem_avail = 31'(need);
                6, 7:       elem_avail = 31'(need + $urandom_range(0, 32'h7FFF_FFFF - need));
                8:          elem_avail = AVAIL_MAX;
                default:    elem_avail = 31'($urandom_range(0, need - 1));
            endcase
            // cut short: the next tag byte drops it
            if (mode >= 54) begin
                k = $urandom_range(1, need - 1);
                while (elem_q.size() > k)
                    void'(elem_q.pop_back());
            end
        end else begin
            t = pick_tag(elem_cmd);
            case ($urandom_range(0, 4))
                0: begin
                    do t = 8'($urandom); while (tag_allowed(t, elem_cmd));
                    elem_q.push_back(t);
                end
                1: elem_q = '{t, LEN_LONG_FORM};
                2: elem_q = '{t, LEN_LONG_FORM | 8'($urandom_range(5, 127))};
                3: begin
                    big = ($urandom_range(0, 3) == 0) ? LEN_CEILING
                        : LEN_CEILING + 32'd1 + $urandom_range(0, 32'h7FFF_FFFE);
                    elem_q = '{t, LEN_LONG_FORM | 8'd4, big[31:24], big[23:16],
                               big[15:8], big[7:0]};
                end
                default: begin
                    len        = $urandom_range(elem_cmd ? 6 : 5, 127);
                    elem_q     = '{t, 8'(len)};
                    elem_avail = 31'(len + 2 + $urandom_range(0, 1000));
                end
            endcase
        end
    endtask

    initial begin
        int unsigned k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: value extremes, every status, zero length and cut bytes
        elem_q = '{TAG_GAUGE, 8'h05, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_element(1'b1, AVAIL_MAX);
        elem_q = '{TAG_INTEGER, 8'h01, 8'h80};
        send_element(1'b0, 31'd3);
        elem_q = '{TAG_UINTEGER, 8'h00};
        send_element(1'b1, 31'd2);
        elem_q = '{TAG_GAUGE, 8'h00};
        send_element(1'b0, 31'd9);
        elem_q = '{TAG_INTEGER, LEN_LONG_FORM};
        send_element(1'b0, 31'd4);
        elem_q = '{TAG_TIMETICKS, 8'h85};
        send_element(1'b1, 31'd4);
        elem_q = '{TAG_COUNTER, 8'h84, 8'h80, 8'h00, 8'h00, 8'h01};
        send_element(1'b0, AVAIL_MAX);
        elem_q = '{TAG_INTEGER, 8'h03};
        send_element(1'b0, 31'd2);
        elem_q = '{TAG_UINTEGER, 8'h05, 8'h01};
        send_element(1'b1, 31'd10);
        elem_q = '{TAG_TIMETICKS, 8'h02};
        send_element(1'b0, 31'd8);
        elem_q = '{TAG_INTEGER, 8'h00};
        send_element(1'b0, 31'd5);

        // random elements across three idling phases
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (random_items >= RANDOM_ITEMS / 3) begin
                tx_idle_pct = 56;
                rx_idle_pct = 19;
            end
            // stray bytes without a tag byte
            if ($urandom_range(0, 99) < 15)
                for (k = $urandom_range(1, 3); k > 0; k--)
                    send_beat(1'($urandom_range(0, 1)), 1'b0, 8'($urandom), 31'($urandom));
            build_element();
            send_element(elem_cmd, elem_avail);
            random_items += elem_q.size();
        end

        // drain
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_fail == 0 && n_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", n_fail, n_pending);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
